@@ hw/rtl/maps_pkg.sv @@
// Shared types, codes and constants for the multi-actuator position sequencer.
// Used by every module in hw/rtl; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package maps_pkg;

  localparam int MOTORS_DEF = 5;
  localparam int MAX_STROKE_DEF = 600;
  localparam logic [31:0] HOME_LIMIT_MS = 32'd200000;
  localparam logic [32:0] HOME_MOTION_PULSES = 33'd3;
  localparam logic [32:0] WRAP_LIMIT = 33'd30000;

  typedef enum logic [1:0] {
    FN_TICK   = 2'd0,
    FN_SAMPLE = 2'd1,
    FN_MOVE   = 2'd2,
    FN_HOME   = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    MD_IDLE    = 3'd0,
    MD_MOVING  = 3'd1,
    MD_HOMING  = 3'd2,
    MD_SETTLED = 3'd3,
    MD_FAULT   = 3'd4
  } mode_t;

  localparam logic [2:0] REG_PPMM      = 3'd0;
  localparam logic [2:0] REG_STOP      = 3'd1;
  localparam logic [2:0] REG_REARM     = 3'd2;
  localparam logic [2:0] REG_TIMEOUT   = 3'd3;
  localparam logic [2:0] REG_STALL_WIN = 3'd4;
  localparam logic [2:0] REG_STALL_MIN = 3'd5;
  localparam logic [2:0] REG_GRACE     = 3'd6;
  localparam logic [2:0] REG_SETTLE    = 3'd7;

  // One classified command handed from the front end to the executor.
  typedef struct packed {
    func_t        func;
    logic [2:0]   motor;
    logic         ignored;
    logic [31:0]  raw_count;
    logic         narrow;
    logic [11:0]  target_mm;  // already clamped
    logic [15:0]  start_delay;
  } cmd_t;

  typedef struct packed {
    logic [15:0] ppmm;
    logic [15:0] stop_tol;
    logic [15:0] rearm_tol;
    logic [21:0] timeout;
    logic [15:0] stall_win;
    logic [15:0] stall_min;
    logic [15:0] grace;
    logic [15:0] settle;
  } cfg_t;

  typedef enum logic [1:0] {
    EX_IDLE  = 2'd0,
    EX_MUL   = 2'd1,
    EX_EMIT  = 2'd2
  } ex_state_t;

endpackage
`default_nettype wire

@@ hw/rtl/maps_front.sv @@
// Front end: accepts input transactions, clamps move targets, flags bad motor
// indexes, and queues commands for the executor. Depends on maps_pkg.
`timescale 1ns / 1ps
`default_nettype none
module maps_front #(
  parameter int MOTORS = maps_pkg::MOTORS_DEF,
  parameter int MAX_STROKE_MM = maps_pkg::MAX_STROKE_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [1:0]    func,
  input  wire logic [2:0]    motor,
  input  wire logic [31:0]   raw_count,
  input  wire logic          narrow,
  input  wire logic [15:0]   target_mm,
  input  wire logic [15:0]   start_delay,
  output logic               cmd_valid,
  input  wire logic          cmd_ready,
  output maps_pkg::cmd_t     cmd
);
  localparam int DEPTH = 2;
  maps_pkg::cmd_t q_r [DEPTH];
  logic [1:0] cnt_r, cnt_nxt;
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  maps_pkg::cmd_t c;
  logic push, pop;

  always_comb begin
    c.func      = maps_pkg::func_t'(func);
    c.motor     = motor;
    c.ignored   = (func != maps_pkg::FN_TICK) && ({29'd0, motor} >= MOTORS);
    c.raw_count = raw_count;
    c.narrow    = narrow;
    if (target_mm[15]) c.target_mm = 12'd0;
    else if ({16'd0, target_mm} > MAX_STROKE_MM) c.target_mm = 12'(MAX_STROKE_MM);
    else c.target_mm = target_mm[11:0];
    c.start_delay = start_delay;
  end

  assign in_ready  = (cnt_r != 2'(DEPTH));
  assign push      = in_valid && in_ready;
  assign cmd_valid = (cnt_r != 2'd0);
  assign pop       = cmd_valid && cmd_ready;
  assign cmd       = q_r[rp_r];

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0; wp_r <= 1'b0; rp_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt; wp_r <= wp_nxt; rp_r <= rp_nxt;
    end
    if (push) q_r[wp_r] <= c;
  end
endmodule
`default_nettype wire

@@ hw/rtl/maps_exec.sv @@
// Executor: holds per-motor state and the millisecond clock, carries out one
// queued command at a time and emits its results. Depends on maps_pkg.
`timescale 1ns / 1ps
`default_nettype none
module maps_exec #(
  parameter int MOTORS = maps_pkg::MOTORS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire maps_pkg::cfg_t cfg,
  input  wire logic          cmd_valid,
  output logic               cmd_ready,
  input  wire maps_pkg::cmd_t cmd,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [2:0]         o_motor,
  output logic               o_fwd,
  output logic               o_rev,
  output logic [2:0]         o_state,
  output logic [31:0]        o_pos,
  output logic               o_ign,
  output logic               o_last
);
  localparam int IW = (MOTORS > 1) ? $clog2(MOTORS) : 1;

  logic [31:0] clock_r, clock_nxt;
  logic [31:0] cnt_r [MOTORS];
  logic [31:0] raw_r [MOTORS];
  logic [17:0] tgt_r [MOTORS];
  maps_pkg::mode_t mode_r [MOTORS];
  logic [31:0] st_r [MOTORS];
  logic [31:0] rp_r [MOTORS];
  logic [31:0] rt_r [MOTORS];
  logic [1:0]  dl_r [MOTORS];

  maps_pkg::ex_state_t st_q, st_nxt;
  maps_pkg::cmd_t cur_r;
  logic [IW-1:0] idx_r, idx_nxt;
  logic [27:0] prod_r;
  logic [IW-1:0] m;

  // Output register.
  logic        ov_r;
  logic [2:0]  om_r, os_r;
  logic        of_r, orv_r, oi_r, ol_r;
  logic [31:0] op_r;

  assign m = cur_r.func == maps_pkg::FN_TICK ? idx_r : IW'(cur_r.motor);

  // Per-motor tick rules on the selected motor.
  logic [31:0] el, sdt;
  logic signed [32:0] err, mvd;
  logic [32:0] aerr, amvd;
  logic [31:0] n_cnt, n_rp, n_rt, n_st;
  logic [17:0] n_tgt;
  maps_pkg::mode_t n_mode;
  logic [1:0] n_dl;
  logic [31:0] cur32, dif;
  logic signed [32:0] dsx;
  logic [31:0] sched;

  always_comb begin
    el   = clock_r - st_r[m];
    sdt  = clock_r - rt_r[m];
    err  = $signed({15'd0, tgt_r[m]}) - $signed({cnt_r[m][31], cnt_r[m]});
    mvd  = $signed({cnt_r[m][31], cnt_r[m]}) - $signed({rp_r[m][31], rp_r[m]});
    aerr = err[32] ? 33'(-err) : 33'(err);
    amvd = mvd[32] ? 33'(-mvd) : 33'(mvd);
    n_cnt = cnt_r[m]; n_rp = rp_r[m]; n_rt = rt_r[m]; n_st = st_r[m];
    n_tgt = tgt_r[m]; n_mode = mode_r[m]; n_dl = dl_r[m];
    if ((mode_r[m] == maps_pkg::MD_MOVING || mode_r[m] == maps_pkg::MD_HOMING) && el[31]) begin
      n_dl = 2'b00;
    end else begin
      unique case (mode_r[m])
        maps_pkg::MD_MOVING: begin
          if (aerr <= {17'd0, cfg.stop_tol}) begin
            n_dl = 2'b00; n_mode = maps_pkg::MD_SETTLED;
          end else if (el > {10'd0, cfg.timeout}) begin
            n_dl = 2'b00; n_mode = maps_pkg::MD_FAULT;
          end else if (amvd >= {17'd0, cfg.stall_min}) begin
            n_rp = cnt_r[m]; n_rt = clock_r; n_dl = err[32] ? 2'b01 : 2'b10;
          end else if (sdt > {16'd0, cfg.stall_win}) begin
            n_dl = 2'b00; n_mode = maps_pkg::MD_FAULT;
          end else begin
            n_dl = err[32] ? 2'b01 : 2'b10;
          end
        end
        maps_pkg::MD_HOMING: begin
          if (amvd > maps_pkg::HOME_MOTION_PULSES) begin
            n_rp = cnt_r[m]; n_rt = clock_r;
          end else if (el <= {16'd0, cfg.grace}) begin
            n_rt = clock_r;
          end
          if (el > {16'd0, cfg.grace} && (clock_r - n_rt) > {16'd0, cfg.settle}) begin
            n_dl = 2'b00; n_cnt = 32'd0; n_tgt = 18'd0; n_mode = maps_pkg::MD_SETTLED;
          end else if (el > maps_pkg::HOME_LIMIT_MS) begin
            n_dl = 2'b00; n_mode = maps_pkg::MD_FAULT;
          end else begin
            n_dl = 2'b01;
          end
        end
        maps_pkg::MD_SETTLED: begin
          if (aerr > {17'd0, cfg.rearm_tol}) begin
            n_mode = maps_pkg::MD_MOVING; n_st = clock_r; n_rp = cnt_r[m]; n_rt = clock_r;
          end else begin
            n_dl = 2'b00;
          end
        end
        default: n_dl = 2'b00;
      endcase
    end
    // Encoder wrap extension.
    cur32 = cur_r.narrow ? {{16{cur_r.raw_count[15]}}, cur_r.raw_count[15:0]}
                         : cur_r.raw_count;
    dif = cur32 - raw_r[m];
    dsx = $signed({dif[31], dif});
    if (cur_r.narrow && dsx > $signed(maps_pkg::WRAP_LIMIT)) dif = dif - 32'd65536;
    else if (cur_r.narrow && dsx < -$signed(maps_pkg::WRAP_LIMIT)) dif = dif + 32'd65536;
    sched = clock_r + {16'd0, cur_r.start_delay};
  end

  assign cmd_ready = (st_q == maps_pkg::EX_IDLE);

  logic emit_go, exec_now;
  always_comb begin
    st_nxt = st_q; idx_nxt = idx_r; clock_nxt = clock_r;
    emit_go = 1'b0; exec_now = 1'b0;
    unique case (st_q)
      maps_pkg::EX_IDLE: if (cmd_valid) begin
        st_nxt = maps_pkg::EX_MUL; idx_nxt = '0;
        if (cmd.func == maps_pkg::FN_TICK) clock_nxt = clock_r + 32'd1;
      end
      maps_pkg::EX_MUL: st_nxt = maps_pkg::EX_EMIT;
      maps_pkg::EX_EMIT: if (!ov_r || out_ready) begin
        exec_now = 1'b1; emit_go = 1'b1;
        if (cur_r.func == maps_pkg::FN_TICK && {{(32-IW){1'b0}}, idx_r} != 32'(MOTORS - 1))
          idx_nxt = idx_r + IW'(1);
        else st_nxt = maps_pkg::EX_IDLE;
      end
      default: st_nxt = maps_pkg::EX_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_q <= maps_pkg::EX_IDLE; idx_r <= '0; clock_r <= 32'd0; ov_r <= 1'b0;
      for (int i = 0; i < MOTORS; i++) begin
        cnt_r[i] <= '0; raw_r[i] <= '0; tgt_r[i] <= '0; mode_r[i] <= maps_pkg::MD_IDLE;
        st_r[i] <= '0; rp_r[i] <= '0; rt_r[i] <= '0; dl_r[i] <= '0;
      end
    end else begin
      st_q <= st_nxt; idx_r <= idx_nxt; clock_r <= clock_nxt;
      ov_r <= emit_go || (ov_r && !out_ready);
      if (exec_now && !cur_r.ignored) begin
        unique case (cur_r.func)
          maps_pkg::FN_TICK: begin
            cnt_r[m] <= n_cnt; rp_r[m] <= n_rp; rt_r[m] <= n_rt; st_r[m] <= n_st;
            tgt_r[m] <= n_tgt; mode_r[m] <= n_mode; dl_r[m] <= n_dl;
          end
          maps_pkg::FN_SAMPLE: if (dif != 32'd0) begin
            cnt_r[m] <= cnt_r[m] + dif; raw_r[m] <= cur32;
          end
          maps_pkg::FN_MOVE: begin
            tgt_r[m] <= prod_r[25:8]; mode_r[m] <= maps_pkg::MD_MOVING;
            st_r[m] <= sched; rp_r[m] <= cnt_r[m]; rt_r[m] <= sched;
          end
          default: begin
            mode_r[m] <= maps_pkg::MD_HOMING;
            st_r[m] <= sched; rp_r[m] <= cnt_r[m]; rt_r[m] <= sched;
          end
        endcase
      end
    end
    if (cmd_valid && cmd_ready) cur_r <= cmd;
    if (st_q == maps_pkg::EX_MUL) prod_r <= cur_r.target_mm * cfg.ppmm;
    if (emit_go) begin
      ol_r <= (cur_r.func != maps_pkg::FN_TICK) ||
              ({{(32-IW){1'b0}}, idx_r} == 32'(MOTORS - 1));
      if (cur_r.ignored) begin
        om_r <= cur_r.motor; of_r <= 1'b0; orv_r <= 1'b0; os_r <= 3'd0;
        op_r <= 32'd0; oi_r <= 1'b1;
      end else begin
        om_r <= 3'(m); oi_r <= 1'b0;
        unique case (cur_r.func)
          maps_pkg::FN_TICK: begin
            of_r <= n_dl[0]; orv_r <= n_dl[1]; os_r <= n_mode; op_r <= n_cnt;
          end
          maps_pkg::FN_SAMPLE: begin
            of_r <= dl_r[m][0]; orv_r <= dl_r[m][1]; os_r <= mode_r[m];
            op_r <= cnt_r[m] + dif;
          end
          maps_pkg::FN_MOVE: begin
            of_r <= dl_r[m][0]; orv_r <= dl_r[m][1]; os_r <= maps_pkg::MD_MOVING;
            op_r <= cnt_r[m];
          end
          default: begin
            of_r <= dl_r[m][0]; orv_r <= dl_r[m][1]; os_r <= maps_pkg::MD_HOMING;
            op_r <= cnt_r[m];
          end
        endcase
      end
    end
  end

  assign out_valid = ov_r;
  assign o_motor = om_r; assign o_fwd = of_r; assign o_rev = orv_r;
  assign o_state = os_r; assign o_pos = op_r; assign o_ign = oi_r; assign o_last = ol_r;
endmodule
`default_nettype wire

@@ hw/rtl/multi_actuator_position_sequencer.sv @@
// Top level of the multi-actuator position sequencer: configuration registers,
// front end and executor. Depends on maps_pkg, maps_front and maps_exec.
`timescale 1ns / 1ps
`default_nettype none
// A tick transaction yields one result per motor in index order, the last with
// tlast; any other transaction yields one result for its motor. The executor
// sets up an item in its EX_MUL state, then emits one result per cycle in
// EX_EMIT while the output is not stalled, using the single shared per-motor
// rule unit. A two-entry queue lets new transactions be accepted while one executes.
module multi_actuator_position_sequencer #(
  parameter int MOTORS = maps_pkg::MOTORS_DEF,
  parameter int MAX_STROKE_MM = maps_pkg::MAX_STROKE_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [21:0] cfg_wdata,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // motor[2:0], raw_count[34:3], narrow_counter[35], target_mm[51:36],
  // start_delay[67:52], zero pad to 72
  input  wire logic [71:0] in_tdata,
  input  wire logic [1:0]  in_tuser,   // func[1:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // motor_id[2:0], drive_fwd[3], drive_rev[4], motor_state[7:5], position[39:8]
  output logic [39:0]      out_tdata,
  output logic             out_tuser,  // ignored
  output logic             out_tlast
);
  maps_pkg::cfg_t cfg_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ppmm <= 16'd20462; cfg_r.stop_tol <= 16'd20; cfg_r.rearm_tol <= 16'd60;
      cfg_r.timeout <= 22'd200000; cfg_r.stall_win <= 16'd1500; cfg_r.stall_min <= 16'd10;
      cfg_r.grace <= 16'd3000; cfg_r.settle <= 16'd1200;
    end else if (cfg_we) begin
      unique case (cfg_index)
        maps_pkg::REG_PPMM:      cfg_r.ppmm <= cfg_wdata[15:0];
        maps_pkg::REG_STOP:      cfg_r.stop_tol <= cfg_wdata[15:0];
        maps_pkg::REG_REARM:     cfg_r.rearm_tol <= cfg_wdata[15:0];
        maps_pkg::REG_TIMEOUT:   cfg_r.timeout <= cfg_wdata;
        maps_pkg::REG_STALL_WIN: cfg_r.stall_win <= cfg_wdata[15:0];
        maps_pkg::REG_STALL_MIN: cfg_r.stall_min <= cfg_wdata[15:0];
        maps_pkg::REG_GRACE:     cfg_r.grace <= cfg_wdata[15:0];
        default:                 cfg_r.settle <= cfg_wdata[15:0];
      endcase
    end
  end

  logic cmd_valid, cmd_ready;
  maps_pkg::cmd_t cmd;

  maps_front #(.MOTORS(MOTORS), .MAX_STROKE_MM(MAX_STROKE_MM)) u_front (
    .clk, .rst_n,
    .in_valid(in_tvalid), .in_ready(in_tready),
    .func(in_tuser), .motor(in_tdata[2:0]), .raw_count(in_tdata[34:3]),
    .narrow(in_tdata[35]), .target_mm(in_tdata[51:36]), .start_delay(in_tdata[67:52]),
    .cmd_valid, .cmd_ready, .cmd
  );

  maps_exec #(.MOTORS(MOTORS)) u_exec (
    .clk, .rst_n, .cfg(cfg_r),
    .cmd_valid, .cmd_ready, .cmd,
    .out_valid(out_tvalid), .out_ready(out_tready),
    .o_motor(out_tdata[2:0]), .o_fwd(out_tdata[3]), .o_rev(out_tdata[4]),
    .o_state(out_tdata[7:5]), .o_pos(out_tdata[39:8]),
    .o_ign(out_tuser), .o_last(out_tlast)
  );
endmodule
`default_nettype wire

@@ tb/sv/multi_actuator_position_sequencer_test.sv @@
// Self-checking testbench for the multi-actuator position sequencer.
// Depends on maps_pkg and the multi_actuator_position_sequencer RTL.
`timescale 1ns / 1ps

class motor_scoreboard;
  logic [15:0] ppmm, stop_b, rearm_b, stall_win, stall_min, grace, settle;
  logic [21:0] timeout;
  logic [31:0] clk_ms;
  logic [31:0] count[5], last_raw[5], start_t[5], ref_p[5], ref_t[5];
  logic [17:0] target[5];
  logic [2:0]  md[5];
  logic [1:0]  lines[5];
  logic [41:0] pending[$];  // {ignored, last, tdata[39:0]}
  int errors;

  function new();
    ppmm = 20462; stop_b = 20; rearm_b = 60; timeout = 200000;
    stall_win = 1500; stall_min = 10; grace = 3000; settle = 1200;
    clk_ms = 0; errors = 0;
    for (int i = 0; i < 5; i++) begin
      count[i] = 0; last_raw[i] = 0; start_t[i] = 0; ref_p[i] = 0;
      ref_t[i] = 0; target[i] = 0; md[i] = maps_pkg::MD_IDLE; lines[i] = 0;
    end
  endfunction

  function void write_reg(logic [2:0] idx, logic [21:0] v);
    case (idx)
      maps_pkg::REG_PPMM:      ppmm = v[15:0];
      maps_pkg::REG_STOP:      stop_b = v[15:0];
      maps_pkg::REG_REARM:     rearm_b = v[15:0];
      maps_pkg::REG_TIMEOUT:   timeout = v;
      maps_pkg::REG_STALL_WIN: stall_win = v[15:0];
      maps_pkg::REG_STALL_MIN: stall_min = v[15:0];
      maps_pkg::REG_GRACE:     grace = v[15:0];
      default:                 settle = v[15:0];
    endcase
  endfunction

  function logic [63:0] absval(longint d);
    return d < 0 ? -d : d;
  endfunction

  function void run_rules(int i);
    logic [31:0] el;
    longint cnt, err;
    logic [63:0] moved;
    el = clk_ms - start_t[i];
    cnt = longint'(signed'(count[i]));
    moved = absval(cnt - longint'(signed'(ref_p[i])));
    err = longint'({46'd0, target[i]}) - cnt;
    if ((md[i] == maps_pkg::MD_MOVING || md[i] == maps_pkg::MD_HOMING) && el[31]) begin
      lines[i] = 0;
      return;
    end
    case (md[i])
      maps_pkg::MD_MOVING: begin
        if (absval(err) <= stop_b) begin
          lines[i] = 0; md[i] = maps_pkg::MD_SETTLED; return;
        end
        if (el > timeout) begin
          lines[i] = 0; md[i] = maps_pkg::MD_FAULT; return;
        end
        if (moved >= stall_min) begin
          ref_p[i] = count[i]; ref_t[i] = clk_ms;
        end else if (clk_ms - ref_t[i] > stall_win) begin
          lines[i] = 0; md[i] = maps_pkg::MD_FAULT; return;
        end
        lines[i] = (err < 0) ? 2'b01 : 2'b10;
      end
      maps_pkg::MD_HOMING: begin
        if (moved > 3) begin
          ref_p[i] = count[i]; ref_t[i] = clk_ms;
        end else if (el <= grace) begin
          ref_t[i] = clk_ms;
        end
        if (el > grace && clk_ms - ref_t[i] > settle) begin
          lines[i] = 0; count[i] = 0; target[i] = 0; md[i] = maps_pkg::MD_SETTLED;
          return;
        end
        if (el > maps_pkg::HOME_LIMIT_MS) begin
          lines[i] = 0; md[i] = maps_pkg::MD_FAULT; return;
        end
        lines[i] = 2'b01;
      end
      maps_pkg::MD_SETTLED: begin
        if (absval(err) > rearm_b) begin
          md[i] = maps_pkg::MD_MOVING; start_t[i] = clk_ms;
          ref_p[i] = count[i]; ref_t[i] = clk_ms;
        end else lines[i] = 0;
      end
      default: lines[i] = 0;
    endcase
  endfunction

  function void push_status(int i, bit lst);
    pending.push_back({1'b0, lst, count[i], md[i], lines[i][1], lines[i][0], 3'(i)});
  endfunction

  function void note_input(logic [1:0] fn, logic [71:0] d);
    logic [2:0] m;
    logic [31:0] cur, dif;
    longint mm;
    m = d[2:0];
    if (fn == maps_pkg::FN_TICK) begin
      clk_ms++;
      for (int i = 0; i < 5; i++) run_rules(i);
      for (int i = 0; i < 5; i++) push_status(i, i == 4);
      return;
    end
    if (m >= 5) begin
      pending.push_back({1'b1, 1'b1, 37'd0, m});
      return;
    end
    if (fn == maps_pkg::FN_SAMPLE) begin
      cur = d[34:3];
      if (d[35]) cur = {{16{cur[15]}}, cur[15:0]};
      dif = cur - last_raw[m];
      if (d[35]) begin
        if (signed'(dif) > 30000) dif -= 65536;
        else if (signed'(dif) < -30000) dif += 65536;
      end
      if (dif != 0) begin
        count[m] += dif; last_raw[m] = cur;
      end
    end else begin
      if (fn == maps_pkg::FN_MOVE) begin
        mm = longint'(signed'(d[51:36]));
        if (mm < 0) mm = 0;
        if (mm > 600) mm = 600;
        target[m] = 18'((mm * ppmm) >> 8);
        md[m] = maps_pkg::MD_MOVING;
      end else md[m] = maps_pkg::MD_HOMING;
      start_t[m] = clk_ms + d[67:52];
      ref_p[m] = count[m];
      ref_t[m] = start_t[m];
    end
    push_status(m, 1);
  endfunction

  function void check_result(logic [39:0] d, logic ign, logic lst);
    logic [41:0] e;
    if (pending.size() == 0) begin
      $error("unexpected result %h", d);
      errors++;
      return;
    end
    e = pending.pop_front();
    if (e[2:0] != d[2:0]) begin $error("motor_id exp %0d got %0d", e[2:0], d[2:0]); errors++; end
    if (e[3] != d[3]) begin $error("drive_fwd exp %0d got %0d", e[3], d[3]); errors++; end
    if (e[4] != d[4]) begin $error("drive_rev exp %0d got %0d", e[4], d[4]); errors++; end
    if (e[7:5] != d[7:5]) begin
      $error("motor_state exp %0d got %0d", e[7:5], d[7:5]); errors++;
    end
    if (e[39:8] != d[39:8]) begin
      $error("position exp %0d got %0d", signed'(e[39:8]), signed'(d[39:8])); errors++;
    end
    if (e[41] != ign) begin $error("ignored exp %0d got %0d", e[41], ign); errors++; end
    if (e[40] != lst) begin $error("last exp %0d got %0d", e[40], lst); errors++; end
  endfunction
endclass

module multi_actuator_position_sequencer_test;
  logic clk = 0, rst_n = 0;
  logic cfg_we = 0;
  logic [2:0] cfg_index = 0;
  logic [21:0] cfg_wdata = 0;
  logic in_tvalid = 0, in_tready;
  logic [71:0] in_tdata = 0;
  logic [1:0] in_tuser = 0;
  logic out_tvalid, out_tready = 0, out_tuser, out_tlast;
  logic [39:0] out_tdata;
  motor_scoreboard sb;
  int cycles = 0;
  int rx_wait = 0;
  bit burst_mode = 0;

  multi_actuator_position_sequencer dut (.*);

  initial forever #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Receiver: checks accepted results and holds ready low for a drawn number
  // of cycles after each one.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        sb.check_result(out_tdata, out_tuser, out_tlast);
        rx_wait = burst_mode ? 0 : int'($urandom_range(0, 8));
        out_tready <= (rx_wait == 0);
      end else if (!out_tready) begin
        rx_wait--;
        out_tready <= (rx_wait <= 0);
      end
    end
  end

  // Valid stays high after an accepted transaction so that the next one can
  // follow with no gap; a gap or drain() drops it.
  task automatic send(maps_pkg::func_t fn, logic [2:0] m, logic [31:0] raw, bit nar,
                      logic [15:0] tmm, logic [15:0] dly);
    int gap;
    gap = burst_mode ? 0 : int'($urandom_range(0, 8));
    if (gap > 0) begin
      in_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1;
    in_tuser <= fn;
    in_tdata <= {4'd0, dly, tmm, nar, raw, m};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_input(fn, {4'd0, dly, tmm, nar, raw, m});
  endtask

  task automatic drain();
    in_tvalid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [21:0] v);
    cfg_we <= 1; cfg_index <= idx; cfg_wdata <= v;
    @(posedge clk);
    sb.write_reg(idx, v);
  endtask

  task automatic ticks(int n);
    for (int k = 0; k < n; k++) send(maps_pkg::FN_TICK, 3'($urandom), $urandom, 0, 0, 0);
  endtask

  // A motion: schedule, then interleave ticks, encoder samples that walk the count
  // toward or away from the target, random samples and commands to bad motors.
  task automatic scenario(int len);
    logic [2:0] m;
    logic [31:0] pos;
    m = 3'($urandom_range(0, 4));
    pos = sb.last_raw[m];
    if ($urandom_range(0, 3) == 0)
      send(maps_pkg::FN_HOME, m, 0, 0, 0, 16'($urandom_range(0, 3)));
    else send(maps_pkg::FN_MOVE, m, 0, 0,
              16'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 3)),
              16'($urandom_range(0, 3)));
    for (int k = 0; k < len; k++) begin
      case ($urandom_range(0, 5))
        0, 1, 2: ticks(1);
        3: begin
          pos = pos + ($urandom_range(0, 1) ? $urandom_range(0, 40) : -$urandom_range(0, 40));
          send(maps_pkg::FN_SAMPLE, m, pos, 1'($urandom_range(0, 1)), 16'($urandom),
               16'($urandom));
        end
        4: send(maps_pkg::FN_SAMPLE, 3'($urandom_range(0, 4)), $urandom,
                1'($urandom_range(0, 1)), 0, 0);
        default: send(maps_pkg::func_t'($urandom_range(1, 3)), 3'($urandom_range(5, 7)),
                      $urandom, 1'($urandom_range(0, 1)), 16'($urandom), 16'($urandom));
      endcase
    end
  endtask

  initial begin
    sb = new();
    repeat (9) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: all kinds, ignored motors, clamps, wrap extension in both widths.
    send(maps_pkg::FN_TICK, 0, 0, 0, 0, 0);
    send(maps_pkg::FN_MOVE, 0, 0, 0, 16'h8000, 0);
    send(maps_pkg::FN_MOVE, 1, 0, 0, 16'h7fff, 2);
    send(maps_pkg::FN_MOVE, 2, 0, 0, 16'd1, 0);
    send(maps_pkg::FN_HOME, 3, 0, 0, 0, 16'hffff);
    send(maps_pkg::FN_HOME, 4, 0, 0, 0, 0);
    send(maps_pkg::FN_MOVE, 7, 32'hffffffff, 1, 16'hffff, 16'hffff);
    send(maps_pkg::FN_SAMPLE, 5, 32'h12345678, 0, 0, 0);
    send(maps_pkg::FN_HOME, 6, 0, 1, 0, 0);
    send(maps_pkg::FN_SAMPLE, 0, 32'h7fffffff, 0, 0, 0);
    send(maps_pkg::FN_SAMPLE, 0, 32'h80000000, 0, 0, 0);
    send(maps_pkg::FN_SAMPLE, 1, 32'h0000_7fff, 1, 0, 0);
    send(maps_pkg::FN_SAMPLE, 1, 32'hffff_8000, 1, 0, 0);
    send(maps_pkg::FN_SAMPLE, 2, 32'hffff_ffff, 1, 0, 0);
    send(maps_pkg::FN_SAMPLE, 2, 32'h0001_0000, 1, 0, 0);
    send(maps_pkg::FN_SAMPLE, 4, 32'h0000_0005, 0, 0, 0);
    ticks(6);

    // Pause the stream until everything has come out.
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          write_reg(maps_pkg::REG_PPMM, 22'd65535); write_reg(maps_pkg::REG_STOP, 0);
          write_reg(maps_pkg::REG_REARM, 0); write_reg(maps_pkg::REG_TIMEOUT, 22'h3fffff);
          write_reg(maps_pkg::REG_STALL_WIN, 0); write_reg(maps_pkg::REG_STALL_MIN, 0);
          write_reg(maps_pkg::REG_GRACE, 0); write_reg(maps_pkg::REG_SETTLE, 0);
        end
        1: begin
          write_reg(maps_pkg::REG_PPMM, 1); write_reg(maps_pkg::REG_STOP, 16'hffff);
          write_reg(maps_pkg::REG_REARM, 16'hffff); write_reg(maps_pkg::REG_TIMEOUT, 0);
          write_reg(maps_pkg::REG_STALL_WIN, 16'hffff);
          write_reg(maps_pkg::REG_STALL_MIN, 16'hffff);
          write_reg(maps_pkg::REG_GRACE, 16'hffff); write_reg(maps_pkg::REG_SETTLE, 16'hffff);
        end
        2: begin
          write_reg(maps_pkg::REG_PPMM, 22'd256); write_reg(maps_pkg::REG_STOP, 3);
          write_reg(maps_pkg::REG_REARM, 8); write_reg(maps_pkg::REG_TIMEOUT, 30);
          write_reg(maps_pkg::REG_STALL_WIN, 6); write_reg(maps_pkg::REG_STALL_MIN, 4);
          write_reg(maps_pkg::REG_GRACE, 4); write_reg(maps_pkg::REG_SETTLE, 5);
        end
        default: begin
          write_reg(maps_pkg::REG_PPMM, 22'd20); write_reg(maps_pkg::REG_STOP, 5);
          write_reg(maps_pkg::REG_REARM, 20); write_reg(maps_pkg::REG_TIMEOUT, 60);
          write_reg(maps_pkg::REG_STALL_WIN, 10); write_reg(maps_pkg::REG_STALL_MIN, 2);
          write_reg(maps_pkg::REG_GRACE, 8); write_reg(maps_pkg::REG_SETTLE, 6);
        end
      endcase
      cfg_we <= 0;
      for (int s = 0; s < 4; s++) begin
        burst_mode = (s == 1);
        scenario(18);
      end
      burst_mode = 0;
      drain();
    end

    drain();
    if (sb.errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end
endmodule

@@ filelist.f @@
hw/rtl/maps_pkg.sv
hw/rtl/maps_front.sv
hw/rtl/maps_exec.sv
hw/rtl/multi_actuator_position_sequencer.sv
tb/sv/multi_actuator_position_sequencer_test.sv
